// File: src/sck_pkg.sv
// Shared types, codes and fixed-point constants of the cubic spline kernel unit.
// No dependencies.
`timescale 1ns / 1ps

package sck_pkg;

    // Fraction bits of the distance, separation and smoothing length inputs.
    localparam int FRAC_BITS = 20;
    localparam int OUT_FRAC  = 24;

    // Scale exponents of the final division, W uses h^3, the others h^4.
    localparam int S3   = 3 * FRAC_BITS + OUT_FRAC - 64;
    localparam int S4   = 4 * FRAC_BITS + OUT_FRAC - 64;
    localparam int NSH3 = (S3 > 0) ? S3 : 0;
    localparam int DSH3 = (S3 < 0) ? -S3 : 0;
    localparam int NSH4 = (S4 > 0) ? S4 : 0;
    localparam int DSH4 = (S4 < 0) ? -S4 : 0;

    // Divider geometry
    localparam int NUM_W   = 176;
    localparam int DEN_W   = 124;
    localparam int QUO_W   = 48;
    localparam int DIV_LAT = QUO_W + 1;

    localparam int SQ_STEPS = 32;

    // 1/pi in Q0.32 times 8, 24 and 48; 1/3 in Q0.32
    localparam logic [35:0] K_KERNEL  = 36'd10937044408;
    localparam logic [35:0] K_DHDW    = 36'd32811133224;
    localparam logic [35:0] K_GRAD    = 36'd65622266448;
    localparam logic [31:0] THIRD_Q32 = 32'd1431655765;

    typedef enum logic [1:0] {
        FN_KERNEL = 2'd0,
        FN_GRAD   = 2'd1,
        FN_DWDH   = 2'd2,
        FN_NONE   = 2'd3
    } t_func;

    // Sideband across the square root
    typedef struct packed {
        logic             vld;
        t_func            func;
        logic             hzero;
        logic [30:0]      r;
        logic [30:0]      h;
        logic [2:0][31:0] mag;
        logic [2:0]       pos;
        logic [61:0]      h2;
    } t_sba;

    // Sideband across the u and direction dividers and the polynomial stages
    typedef struct packed {
        logic         vld;
        t_func        func;
        logic         hzero;
        logic         kill;
        logic         half;
        logic         third;
        logic [2:0]   lnz;
        logic [2:0]   pos;
        logic [92:0]  d3;
        logic [123:0] d4;
    } t_sbb;

    // Sideband across the final scaling dividers
    typedef struct packed {
        logic       vld;
        t_func      func;
        logic       hzero;
        logic       kill;
        logic [2:0] lnz;
        logic [2:0] neg;
    } t_sbc;

    typedef struct packed {
        logic [47:0] scalar;
        logic [47:0] gx;
        logic [47:0] gy;
        logic [47:0] gz;
        logic        ovf;
        logic        badh;
    } t_res;

endpackage

// File: src/sck_div.sv
// Pipelined restoring divider, one quotient bit per stage, with a range flag.
// Depends on sck_pkg.
`timescale 1ns / 1ps

module sck_div import sck_pkg::*; (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [QUO_W-1:0] o_quo,
    output logic             o_big
);

    logic [NUM_W-1:0] r_rem [DIV_LAT];
    logic [DEN_W-1:0] r_den [DIV_LAT];
    logic [QUO_W-1:0] r_quo [DIV_LAT];
    logic             r_big [DIV_LAT];

    // quotient would not fit in QUO_W bits
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= i_num;
            r_den[0] <= i_den;
            r_quo[0] <= '0;
            r_big[0] <= i_num >= (NUM_W'(i_den) << QUO_W);
        end
    end

    for (genvar k = 1; k < DIV_LAT; k++) begin : g_step
        localparam int B = QUO_W - k;
        logic [NUM_W-1:0] n_sh;
        logic             n_fit;
        assign n_sh  = NUM_W'(r_den[k-1]) << B;
        assign n_fit = r_rem[k-1] >= n_sh;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_fit ? (r_rem[k-1] - n_sh) : r_rem[k-1];
                r_den[k] <= r_den[k-1];
                r_quo[k] <= r_quo[k-1] | (QUO_W'(n_fit) << B);
                r_big[k] <= r_big[k-1];
            end
        end
    end

    assign o_quo = r_quo[DIV_LAT-1];
    assign o_big = r_big[DIV_LAT-1];

endmodule

// File: src/sck_isqrt.sv
// Pipelined integer square root of a 64-bit radicand, one result bit per stage.
// Depends on sck_pkg.
`timescale 1ns / 1ps

module sck_isqrt import sck_pkg::*; (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_rad,
    output logic [31:0] o_root
);

    logic [63:0] r_x [SQ_STEPS];
    logic [63:0] r_r [SQ_STEPS];

    for (genvar j = 0; j < SQ_STEPS; j++) begin : g_step
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * j);
        logic [63:0] n_xin;
        logic [63:0] n_rin;
        logic [63:0] n_t;
        if (j == 0) begin : g_first
            assign n_xin = i_rad;
            assign n_rin = '0;
        end else begin : g_rest
            assign n_xin = r_x[j-1];
            assign n_rin = r_r[j-1];
        end
        assign n_t = n_rin + BIT;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (n_xin >= n_t) begin
                    r_x[j] <= n_xin - n_t;
                    r_r[j] <= (n_rin >> 1) + BIT;
                end else begin
                    r_x[j] <= n_xin;
                    r_r[j] <= n_rin >> 1;
                end
            end
        end
    end

    assign o_root = r_r[SQ_STEPS-1][31:0];

endmodule

// File: src/sph_cubic_spline_kernel_unit.sv
// Top level of the M4 cubic spline SPH kernel unit.
// Depends on sck_pkg, sck_isqrt and sck_div.
`timescale 1ns / 1ps

// Streams one beat per clock while o_in_ready is high: a new item may enter every
// cycle and results leave in order (3 input stages, 32 square root stages, 2 setup
// stages, a 49-stage divider for u and the direction cosines, 7 polynomial and
// product stages, a 49-stage scaling divider, and the output register). The whole
// pipe advances together; a two-entry output buffer lets input keep flowing while
// a result waits, and o_in_ready drops only once both entries are full.
// func selects W, the gradient vector or dW/dh. For the gradient the distance is
// the floored length of the separation vector. h of zero gives zeros and o_bad_h.
// Results are Q24.24, saturated with o_overflow. i_cfg_we/i_cfg_data write the
// constant-inner-gradient mode bit; write it only while the unit is empty.

module sph_cubic_spline_kernel_unit import sck_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_func,
    input  logic [30:0]        i_dist_req,
    input  logic signed [31:0] i_sep_x,
    input  logic signed [31:0] i_sep_y,
    input  logic signed [31:0] i_sep_z,
    input  logic [30:0]        i_smooth_len,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [47:0] o_scalar_val,
    output logic signed [47:0] o_grad_x,
    output logic signed [47:0] o_grad_y,
    output logic signed [47:0] o_grad_z,
    output logic               o_overflow,
    output logic               o_bad_h
);

    logic r_mode;
    logic w_en;

    // ---------------- input stages ----------------
    t_sba        r_p1, r_p2, r_p3;
    logic [63:0] r_p2_sq [3];
    logic [63:0] r_p3_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1.vld <= 1'b0;
            r_p2.vld <= 1'b0;
            r_p3.vld <= 1'b0;
        end else if (w_en) begin
            r_p1.vld    <= i_in_valid;
            r_p1.func   <= t_func'(i_func);
            r_p1.hzero  <= (i_smooth_len == '0);
            r_p1.r      <= i_dist_req;
            r_p1.h      <= i_smooth_len;
            r_p1.mag[0] <= i_sep_x[31] ? 32'(-i_sep_x) : 32'(i_sep_x);
            r_p1.mag[1] <= i_sep_y[31] ? 32'(-i_sep_y) : 32'(i_sep_y);
            r_p1.mag[2] <= i_sep_z[31] ? 32'(-i_sep_z) : 32'(i_sep_z);
            r_p1.pos[0] <= !i_sep_x[31] && (i_sep_x != '0);
            r_p1.pos[1] <= !i_sep_y[31] && (i_sep_y != '0);
            r_p1.pos[2] <= !i_sep_z[31] && (i_sep_z != '0);
            r_p1.h2     <= 62'(i_smooth_len) * 62'(i_smooth_len);
            r_p2        <= r_p1;
            r_p3        <= r_p2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_p2_sq[i] <= 64'(r_p1.mag[i]) * 64'(r_p1.mag[i]);
            end
            r_p3_sum <= r_p2_sq[0] + r_p2_sq[1] + r_p2_sq[2];
        end
    end

    // ---------------- vector length ----------------
    logic [31:0] w_rg;
    t_sba        r_sba [SQ_STEPS];
    t_sba        w_sa;

    sck_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_rad  (r_p3_sum),
        .o_root (w_rg)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < SQ_STEPS; j++) r_sba[j].vld <= 1'b0;
        end else if (w_en) begin
            r_sba[0] <= r_p3;
            for (int j = 1; j < SQ_STEPS; j++) r_sba[j] <= r_sba[j-1];
        end
    end
    assign w_sa = r_sba[SQ_STEPS-1];

    // ---------------- setup: u operand, region tests, h powers ----------------
    t_sba        r_p4;
    logic [31:0] r_p4_x, r_p4_rg;
    logic        r_p4_inr, r_p4_half, r_p4_third, r_p4_rgz;
    logic [62:0] r_p4_h3a;
    logic [60:0] r_p4_h3b;
    logic [63:0] r_p4_a0;
    logic [61:0] r_p4_a1;
    logic [59:0] r_p4_a2;
    logic [31:0] n_x;

    assign n_x = (w_sa.func == FN_GRAD) ? w_rg : {1'b0, w_sa.r};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p4.vld <= 1'b0;
        end else if (w_en) begin
            r_p4       <= w_sa;
            r_p4_x     <= n_x;
            r_p4_rg    <= w_rg;
            r_p4_inr   <= n_x < {1'b0, w_sa.h};
            r_p4_half  <= {n_x, 1'b0} <= {2'b0, w_sa.h};
            r_p4_third <= (34'(n_x) * 34'd3) <= {3'b0, w_sa.h};
            r_p4_rgz   <= (w_sa.func == FN_GRAD) && (w_rg == '0);
            r_p4_h3a   <= 63'(w_sa.h2[31:0]) * 63'(w_sa.h);
            r_p4_h3b   <= 61'(w_sa.h2[61:32]) * 61'(w_sa.h);
            r_p4_a0    <= 64'(w_sa.h2[31:0]) * 64'(w_sa.h2[31:0]);
            r_p4_a1    <= 62'(w_sa.h2[31:0]) * 62'(w_sa.h2[61:32]);
            r_p4_a2    <= 60'(w_sa.h2[61:32]) * 60'(w_sa.h2[61:32]);
        end
    end

    t_sbb        r_p5;
    logic [31:0] r_p5_x, r_p5_rg;
    logic [31:0] r_p5_mag [3];
    logic [30:0] r_p5_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p5.vld <= 1'b0;
        end else if (w_en) begin
            r_p5.vld   <= r_p4.vld;
            r_p5.func  <= r_p4.func;
            r_p5.hzero <= r_p4.hzero;
            r_p5.kill  <= (r_p4.func == FN_NONE) || r_p4.hzero || !r_p4_inr || r_p4_rgz;
            r_p5.half  <= r_p4_half;
            r_p5.third <= r_p4_third;
            for (int i = 0; i < 3; i++) r_p5.lnz[i] <= (r_p4.mag[i] != '0);
            r_p5.pos   <= r_p4.pos;
            r_p5.d3    <= 93'(r_p4_h3a) + (93'(r_p4_h3b) << 32);
            r_p5.d4    <= 124'(r_p4_a0) + (124'(r_p4_a1) << 33) + (124'(r_p4_a2) << 64);
            r_p5_x     <= r_p4_x;
            r_p5_rg    <= r_p4_rg;
            for (int i = 0; i < 3; i++) r_p5_mag[i] <= r_p4.mag[i];
            r_p5_h     <= r_p4.h;
        end
    end

    // ---------------- u = x/h and direction cosines |dr_i|/rg ----------------
    logic [QUO_W-1:0] w_uq;
    logic [QUO_W-1:0] w_cq [3];
    logic             w_ubig;
    logic             w_cbig [3];

    sck_div u_div_u (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (NUM_W'(r_p5_x) << 32),
        .i_den (DEN_W'(r_p5_h)),
        .o_quo (w_uq),
        .o_big (w_ubig)
    );

    for (genvar i = 0; i < 3; i++) begin : g_cdiv
        sck_div u_div_c (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_num (NUM_W'(r_p5_mag[i]) << 32),
            .i_den (DEN_W'(r_p5_rg)),
            .o_quo (w_cq[i]),
            .o_big (w_cbig[i])
        );
    end

    t_sbb r_sbb [DIV_LAT];
    t_sbb w_sb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < DIV_LAT; j++) r_sbb[j].vld <= 1'b0;
        end else if (w_en) begin
            r_sbb[0] <= r_p5;
            for (int j = 1; j < DIV_LAT; j++) r_sbb[j] <= r_sbb[j-1];
        end
    end
    assign w_sb = r_sbb[DIV_LAT-1];

    // ---------------- polynomial stages ----------------
    t_sbb        r_q1, r_q2, r_q3, r_q4, r_q5, r_q6;
    logic [32:0] r_q1_c [3];
    logic [32:0] r_q2_c [3];
    logic [32:0] r_q3_c [3];
    logic [32:0] r_q4_c [3];
    logic [32:0] r_q5_c [3];
    logic [31:0] r_q1_u, r_q1_u2, r_q2_u2, r_q2_u3;
    logic [32:0] r_q1_d, r_q1_dd, r_q1_tw, r_q2_dd, r_q2_d3x, r_q2_pe, r_q2_gh;
    logic [33:0] r_q1_tu;
    logic [35:0] r_q3_mag, r_q3_k;
    logic        r_q3_neg, r_q4_neg, r_q5_neg, r_q6_neg;
    logic [53:0] r_q4_pa, r_q4_pb;
    logic [71:0] r_q5_m, r_q6_m;
    logic [56:0] r_q6_p [3][3];
    logic [31:0] w_u;
    logic [65:0] n_dd, n_d3x, n_pe, n_gh;
    logic [35:0] n_fh, n_t, n_f, n_mag, n_k;
    logic        n_neg;

    // a quotient beyond range only comes with a killed or unused lane
    assign w_u   = w_uq[31:0];
    assign n_dd  = 66'(33'h1_0000_0000 - 33'(w_u)) * 66'(33'h1_0000_0000 - 33'(w_u));
    assign n_d3x = 66'(r_q1_dd) * 66'(r_q1_d);
    assign n_pe  = 66'(r_q1_dd) * 66'(r_q1_tw);
    assign n_gh  = 66'(r_q1_u) * 66'(r_q1_tu);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q1.vld <= 1'b0;
            r_q2.vld <= 1'b0;
        end else if (w_en) begin
            r_q1     <= w_sb;
            r_q1_u   <= w_u;
            r_q1_u2  <= 32'((64'(w_u) * 64'(w_u)) >> 32);
            r_q1_d   <= 33'h1_0000_0000 - 33'(w_u);
            r_q1_dd  <= n_dd[64:32];
            r_q1_tu  <= 34'h2_0000_0000 - 34'(w_u) * 34'd3;
            r_q1_tw  <= {w_u, 1'b0} - 33'h1_0000_0000;
            r_q2     <= r_q1;
            r_q2_u2  <= r_q1_u2;
            r_q2_u3  <= 32'((64'(r_q1_u2) * 64'(r_q1_u)) >> 32);
            r_q2_dd  <= r_q1_dd;
            r_q2_d3x <= n_d3x[64:32];
            r_q2_pe  <= n_pe[64:32];
            r_q2_gh  <= n_gh[64:32];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r_q1_c[i] <= w_cq[i][32:0];
                r_q2_c[i] <= r_q1_c[i];
                r_q3_c[i] <= r_q2_c[i];
                r_q4_c[i] <= r_q3_c[i];
                r_q5_c[i] <= r_q4_c[i];
            end
        end
    end

    // magnitude and sign of the polynomial, and the 1/pi scale for the selector
    assign n_fh = 36'h1_0000_0000 + 36'(r_q2_u3) * 36'd6 - 36'(r_q2_u2) * 36'd6;
    assign n_t  = 36'(r_q2_u2) * 36'd10 - 36'(r_q2_u3) * 36'd12;
    assign n_f  = r_q2.half ? n_fh : 36'({r_q2_d3x, 1'b0});

    always_comb begin
        n_mag = '0;
        n_k   = K_KERNEL;
        n_neg = 1'b0;
        unique case (r_q2.func)
            FN_KERNEL: begin
                n_mag = n_f;
            end
            FN_DWDH: begin
                n_k = K_DHDW;
                if (!r_q2.half) begin
                    n_mag = 36'({r_q2_pe, 1'b0});
                end else if (n_t <= 36'h1_0000_0000) begin
                    n_mag = 36'h1_0000_0000 - n_t;
                    n_neg = 1'b1;
                end else begin
                    n_mag = n_t - 36'h1_0000_0000;
                end
            end
            FN_GRAD: begin
                n_k = K_GRAD;
                if (r_mode && r_q2.third) n_mag = 36'(THIRD_Q32);
                else if (r_q2.half)       n_mag = 36'(r_q2_gh);
                else                      n_mag = 36'(r_q2_dd);
            end
            FN_NONE: begin
                n_mag = '0;
            end
            default: begin
                n_mag = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q3.vld <= 1'b0;
            r_q4.vld <= 1'b0;
            r_q5.vld <= 1'b0;
            r_q6.vld <= 1'b0;
        end else if (w_en) begin
            r_q3     <= r_q2;
            r_q3_mag <= n_mag;
            r_q3_k   <= n_k;
            r_q3_neg <= n_neg;
            r_q4     <= r_q3;
            r_q4_pa  <= 54'(r_q3_k) * 54'(r_q3_mag[35:18]);
            r_q4_pb  <= 54'(r_q3_k) * 54'(r_q3_mag[17:0]);
            r_q4_neg <= r_q3_neg;
            r_q5     <= r_q4;
            r_q5_m   <= (72'(r_q4_pa) << 18) + 72'(r_q4_pb);
            r_q5_neg <= r_q4_neg;
            r_q6     <= r_q5;
            r_q6_m   <= r_q5_m;
            r_q6_neg <= r_q5_neg;
        end
    end

    // magnitude times direction cosine, in 24-bit slices
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_q6_p[i][j] <= 57'(r_q5_m[24*j +: 24]) * 57'(r_q5_c[i]);
                end
            end
        end
    end

    // ---------------- scaling operands ----------------
    t_sbc             r_q7;
    logic [NUM_W-1:0] r_q7_num [3];
    logic [DEN_W-1:0] r_q7_den [3];
    logic [104:0]     n_mc [3];
    logic [DEN_W-1:0] n_den4;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_mc[i] = 105'(r_q6_p[i][0]) + (105'(r_q6_p[i][1]) << 24)
                    + (105'(r_q6_p[i][2]) << 48);
        end
    end
    assign n_den4 = r_q6.d4 << DSH4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q7.vld <= 1'b0;
        end else if (w_en) begin
            r_q7.vld   <= r_q6.vld;
            r_q7.func  <= r_q6.func;
            r_q7.hzero <= r_q6.hzero;
            r_q7.kill  <= r_q6.kill;
            if (r_q6.func == FN_GRAD) begin
                r_q7.lnz <= r_q6.lnz;
                r_q7.neg <= r_q6.pos;
            end else begin
                r_q7.lnz <= 3'b001;
                r_q7.neg <= {2'b00, r_q6_neg};
            end
        end
    end

    // lane 0 carries the scalar for W and dW/dh, the x component for the gradient
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                if (i == 0 && r_q6.func == FN_KERNEL) begin
                    r_q7_num[i] <= NUM_W'(r_q6_m) << NSH3;
                    r_q7_den[i] <= DEN_W'(r_q6.d3) << DSH3;
                end else if (i == 0 && r_q6.func != FN_GRAD) begin
                    r_q7_num[i] <= NUM_W'(r_q6_m) << NSH4;
                    r_q7_den[i] <= n_den4;
                end else begin
                    r_q7_num[i] <= NUM_W'(n_mc[i][104:32]) << NSH4;
                    r_q7_den[i] <= n_den4;
                end
            end
        end
    end

    // ---------------- final scaling by h^3 or h^4 ----------------
    logic [QUO_W-1:0] w_fq [3];
    logic             w_fbig [3];

    for (genvar i = 0; i < 3; i++) begin : g_fdiv
        sck_div u_div_f (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_num (r_q7_num[i]),
            .i_den (r_q7_den[i]),
            .o_quo (w_fq[i]),
            .o_big (w_fbig[i])
        );
    end

    t_sbc r_sbc [DIV_LAT];
    t_sbc w_sc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < DIV_LAT; j++) r_sbc[j].vld <= 1'b0;
        end else if (w_en) begin
            r_sbc[0] <= r_q7;
            for (int j = 1; j < DIV_LAT; j++) r_sbc[j] <= r_sbc[j-1];
        end
    end
    assign w_sc = r_sbc[DIV_LAT-1];

    // saturate, apply sign, mask lanes with no result
    logic [47:0] n_lane [3];
    logic [2:0]  n_lov;
    t_res        n_res;

    always_comb begin
        logic [47:0] cap;
        logic [47:0] val;
        logic        sat;
        logic        on;
        for (int i = 0; i < 3; i++) begin
            cap = w_sc.neg[i] ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
            sat = w_fbig[i] || (w_fq[i] > cap);
            val = sat ? cap : w_fq[i];
            on  = !w_sc.kill && w_sc.lnz[i];
            n_lane[i] = on ? (w_sc.neg[i] ? (48'd0 - val) : val) : '0;
            n_lov[i]  = on && sat;
        end
        n_res.scalar = (w_sc.func == FN_GRAD) ? '0 : n_lane[0];
        n_res.gx     = (w_sc.func == FN_GRAD) ? n_lane[0] : '0;
        n_res.gy     = n_lane[1];
        n_res.gz     = n_lane[2];
        n_res.ovf    = |n_lov;
        n_res.badh   = w_sc.hzero && (w_sc.func != FN_NONE);
    end

    // ---------------- two-entry output buffer ----------------
    t_res r_out, r_skid;
    logic r_ov, r_sv;
    logic w_taken;

    assign w_en    = !r_sv;
    assign w_taken = r_ov && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (r_sv) begin
            if (w_taken) begin
                r_out <= r_skid;
                r_sv  <= 1'b0;
            end
        end else if (w_sc.vld) begin
            if (!r_ov || w_taken) begin
                r_out <= n_res;
                r_ov  <= 1'b1;
            end else begin
                r_skid <= n_res;
                r_sv   <= 1'b1;
            end
        end else if (w_taken) begin
            r_ov <= 1'b0;
        end
    end

    assign o_in_ready   = w_en;
    assign o_out_valid  = r_ov;
    assign o_scalar_val = r_out.scalar;
    assign o_grad_x     = r_out.gx;
    assign o_grad_y     = r_out.gy;
    assign o_grad_z     = r_out.gz;
    assign o_overflow   = r_out.ovf;
    assign o_bad_h      = r_out.badh;

endmodule
